>>> src/mie_pkg.sv
package mie_pkg;

  // Operand width of value, modulus and inverse.
  localparam int VALUE_WIDTH = 31;
  // Bezout coefficient: magnitude stays below the modulus, plus sign and guard bit.
  localparam int COEF_WIDTH = VALUE_WIDTH + 2;
  // Alignment shift count, 0 .. VALUE_WIDTH-1.
  localparam int SHIFT_WIDTH = $clog2(VALUE_WIDTH);
  localparam int IN_DATA_WIDTH = ((2 * VALUE_WIDTH + 7) / 8) * 8;
  localparam int OUT_DATA_WIDTH = ((VALUE_WIDTH + 7) / 8) * 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ALIGN,
    ST_SUB,
    ST_FINAL
  } state_t;

  typedef struct packed {
    logic load;       // take a new item into the remainder/coefficient registers
    logic start_div;  // begin one Euclid step: divisor copy, shift count cleared
    logic shift_up;   // double the aligned divisor
    logic sub_step;   // one restoring subtract, then halve or swap
    logic finish;     // normalise and register the result
  } dp_cmd_t;

  typedef struct packed {
    logic b_zero;     // remainder sequence has ended
    logic can_shift;  // doubled divisor still fits under the remainder
    logic k_zero;     // last quotient bit of this step
  } dp_status_t;

endpackage

>>> src/mie_datapath.sv
module mie_datapath (
  input  logic                              clk,
  input  mie_pkg::dp_cmd_t                  cmd,
  output mie_pkg::dp_status_t               status,
  input  logic [mie_pkg::VALUE_WIDTH-1:0]   value_in,
  input  logic [mie_pkg::VALUE_WIDTH-1:0]   modulus_in,
  output logic [mie_pkg::VALUE_WIDTH-1:0]   inverse,
  output logic                              no_inverse
);
  import mie_pkg::*;

  logic [VALUE_WIDTH-1:0] a;    // r_prev
  logic [VALUE_WIDTH-1:0] b;    // r_cur
  logic [VALUE_WIDTH-1:0] d;    // r_cur << k
  logic [VALUE_WIDTH-1:0] m;    // modulus
  logic [COEF_WIDTH-1:0]  ca;   // c_prev, two's complement
  logic [COEF_WIDTH-1:0]  cb;   // c_cur
  logic [SHIFT_WIDTH-1:0] k;
  logic [VALUE_WIDTH-1:0] inverse_q;
  logic                   no_inverse_q;

  logic [VALUE_WIDTH:0]   d_up;
  logic [VALUE_WIDTH:0]   diff;
  logic                   ge;
  logic [VALUE_WIDTH-1:0] a_after;
  logic [COEF_WIDTH-1:0]  cb_shift;
  logic [COEF_WIDTH-1:0]  ca_after;
  logic [COEF_WIDTH-1:0]  s_wide;
  logic [VALUE_WIDTH:0]   s_low;
  logic [VALUE_WIDTH:0]   s_red;
  logic                   inv_ok;

  assign d_up     = {d, 1'b0};
  assign diff     = {1'b0, a} - {1'b0, d};
  assign ge       = ~diff[VALUE_WIDTH];
  assign a_after  = ge ? diff[VALUE_WIDTH-1:0] : a;
  // q * c_cur is built from the same shifted copies as q * r_cur
  assign cb_shift = cb << k;
  assign ca_after = ge ? (ca - cb_shift) : ca;

  // sign fix, then one conditional subtract brings s into 0 .. m-1
  assign s_wide = ca[COEF_WIDTH-1] ? (ca + COEF_WIDTH'(m)) : ca;
  assign s_low  = s_wide[VALUE_WIDTH:0];
  assign s_red  = (s_low >= {1'b0, m}) ? (s_low - {1'b0, m}) : s_low;
  assign inv_ok = (m != '0) && (a == VALUE_WIDTH'(1));

  assign status.b_zero    = (b == '0);
  assign status.can_shift = (d_up <= {1'b0, a});
  assign status.k_zero    = (k == '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a  <= value_in;
      b  <= modulus_in;
      m  <= modulus_in;
      ca <= COEF_WIDTH'(1);
      cb <= '0;
    end
    if (cmd.start_div) begin
      d <= b;
      k <= '0;
    end
    if (cmd.shift_up) begin
      d <= d_up[VALUE_WIDTH-1:0];
      k <= k + SHIFT_WIDTH'(1);
    end
    if (cmd.sub_step) begin
      if (k == '0) begin
        a  <= b;
        b  <= a_after;
        ca <= cb;
        cb <= ca_after;
      end else begin
        a  <= a_after;
        ca <= ca_after;
        d  <= d >> 1;
        k  <= k - SHIFT_WIDTH'(1);
      end
    end
    if (cmd.finish) begin
      inverse_q    <= inv_ok ? s_red[VALUE_WIDTH-1:0] : '0;
      no_inverse_q <= ~inv_ok;
    end
  end

  assign inverse    = inverse_q;
  assign no_inverse = no_inverse_q;

endmodule

>>> src/mie_controller.sv
module mie_controller (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output mie_pkg::dp_cmd_t    cmd,
  input  mie_pkg::dp_status_t status
);
  import mie_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid_q;
  logic   out_free;

  assign out_free = ~out_valid_q | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_CHECK;
      ST_CHECK: state_next = status.b_zero ? ST_FINAL : ST_ALIGN;
      ST_ALIGN: if (!status.can_shift) state_next = ST_SUB;
      ST_SUB:   if (status.k_zero) state_next = ST_CHECK;
      ST_FINAL: if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        // nothing is taken while reset is held
        in_ready = ~rst;
        cmd.load = in_valid & ~rst;
      end
      ST_CHECK: cmd.start_div = ~status.b_zero;
      ST_ALIGN: cmd.shift_up  = status.can_shift;
      ST_SUB:   cmd.sub_step  = 1'b1;
      ST_FINAL: cmd.finish    = out_free;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

  assign out_valid = out_valid_q;

endmodule

>>> src/modular_inverse_egcd.sv
// Modular inverse by the extended Euclidean algorithm.
//
// Input channel s_*: one item carries value and modulus. The inverse of value
// modulo modulus comes back on m_*, in 0 .. modulus-1, with m_tuser set and
// zero data when the gcd is not 1. A modulus of one gives 0, flag clear.
//
// Timing: one item at a time. Each Euclid step runs through a check state, an
// alignment phase that doubles the divisor k times and a subtract phase of k+1
// restoring subtracts, k = floor(log2(quotient)) (0 for a zero quotient).
// m_tvalid rises after the last step, a closing check and the result write;
// with the receiver ready the next item is taken from the idle state right
// after the write. The shared shift/subtract datapath sets the pace.
//
// The result sits in an output register. s_tready rises again as soon as the
// result is registered; a stalled receiver holds m_tvalid and data, and the
// block then only waits in its final state before writing the next result.
// Reset (rst, synchronous): controller returns to idle, s_tready stays low while
// rst is high, any pending result is dropped. No clearing pass is needed.
module modular_inverse_egcd (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // [30:0] value, [61:31] modulus, rest zero
  input  logic [mie_pkg::IN_DATA_WIDTH-1:0]    s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // [30:0] inverse, rest zero
  output logic [mie_pkg::OUT_DATA_WIDTH-1:0]   m_tdata,
  // [0] no_inverse
  output logic [0:0]                           m_tuser
);
  import mie_pkg::*;

  dp_cmd_t                cmd;
  dp_status_t             status;
  logic [VALUE_WIDTH-1:0] inverse;
  logic                   no_inverse;

  mie_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cmd       (cmd),
    .status    (status)
  );

  mie_datapath u_dp (
    .clk        (clk),
    .cmd        (cmd),
    .status     (status),
    .value_in   (s_tdata[VALUE_WIDTH-1:0]),
    .modulus_in (s_tdata[2*VALUE_WIDTH-1:VALUE_WIDTH]),
    .inverse    (inverse),
    .no_inverse (no_inverse)
  );

  assign m_tdata    = OUT_DATA_WIDTH'(inverse);
  assign m_tuser[0] = no_inverse;

endmodule

>>> src/mie_checker.sv
module mie_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_tvalid,
  input logic                               s_tready,
  input logic [mie_pkg::IN_DATA_WIDTH-1:0]  s_tdata,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [mie_pkg::OUT_DATA_WIDTH-1:0] m_tdata,
  input logic [0:0]                         m_tuser
);

  // no pending result right after reset
  a_reset_clears: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("result valid after reset");

  // stalled result must stay offered
  a_stall_hold: assert property (@(posedge clk)
    (!rst && m_tvalid && !m_tready) ##1 !rst |-> m_tvalid)
    else $error("result dropped while stalled");

  // one item at a time: busy straight after accepting
  a_busy_after_accept: assert property (@(posedge clk)
    (!rst && s_tvalid && s_tready) ##1 !rst |-> !s_tready)
    else $error("second item taken while working");

  // no inverse means zero data
  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
    else $error("inverse not zero with flag set");

endmodule

bind modular_inverse_egcd mie_checker u_mie_checker (.*);
